FILE: rtl/core/substring_first_match_defines.svh
`ifndef SUBSTRING_FIRST_MATCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_DEFINES_SVH

// same-cycle check, sampled on clk, off while rst_n is low
`define SFM_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle check, sampled on clk, off while rst_n is low
`define SFM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/sfm_pkg.sv
`default_nettype none
package sfm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 4096;
  localparam int BYTE_W      = 8;
  localparam int OFF_W       = 12;
  localparam int PLEN_W      = $clog2(PATTERN_MAX + 1);
  localparam int TCNT_W      = $clog2(TEXT_MAX + 1);
  localparam int CMP_W       = (TCNT_W > PLEN_W) ? TCNT_W : PLEN_W;
  localparam int WIDE_W      = CMP_W + OFF_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] match_start;
  } out_word_t;

  typedef struct packed {
    logic              is_text;
    logic              restart;
    logic              store;
    logic              win;
    logic              check;
    logic              last;
    logic [BYTE_W-1:0] data_byte;
    logic [OFF_W-1:0]  offset;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [PLEN_W-1:0] pat_len;
    logic [TCNT_W-1:0] text_cnt;
  } front_stat_t;

  typedef struct packed {
    logic              busy;
    logic [PLEN_W-1:0] pat_len;
  } back_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/sfm_front.sv
`default_nettype none
module sfm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sfm_pkg::in_word_t   in_data,
  input  wire sfm_pkg::q_stat_t    q_stat,
  output logic                     push,
  output sfm_pkg::cmd_t            cmd,
  output sfm_pkg::front_stat_t     f_stat
);

  logic                             pat_complete_r, pat_complete_nxt;
  logic [sfm_pkg::PLEN_W-1:0]       pat_len_r, pat_len_nxt, len_base;
  logic [sfm_pkg::TCNT_W-1:0]       text_cnt_r, text_cnt_nxt, cnt_new;
  logic [sfm_pkg::WIDE_W-1:0]       cnt_x, len_x, diff_x;
  logic                             accept, emit, room;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    len_base = pat_complete_r ? '0 : pat_len_r;
    room     = text_cnt_r < sfm_pkg::TCNT_W'(sfm_pkg::TEXT_MAX);
    cnt_new  = room ? sfm_pkg::TCNT_W'(text_cnt_r + 1'b1) : text_cnt_r;
    cnt_x    = sfm_pkg::WIDE_W'(cnt_new);
    len_x    = sfm_pkg::WIDE_W'(pat_len_r);
    diff_x   = sfm_pkg::WIDE_W'(cnt_x - len_x);

    pat_complete_nxt = pat_complete_r;
    pat_len_nxt      = pat_len_r;
    text_cnt_nxt     = text_cnt_r;

    cmd           = '0;
    cmd.data_byte = in_data.data_byte;
    cmd.last      = in_data.last;
    emit          = 1'b0;

    unique case (in_data.kind)
      sfm_pkg::KIND_PATTERN: begin
        emit        = 1'b1;
        cmd.is_text = 1'b0;
        cmd.restart = pat_complete_r;
        cmd.store   = len_base < sfm_pkg::PLEN_W'(sfm_pkg::PATTERN_MAX);
        if (accept) begin
          pat_len_nxt      = cmd.store ? sfm_pkg::PLEN_W'(len_base + 1'b1) : len_base;
          pat_complete_nxt = in_data.last;
          if (pat_complete_r) begin
            text_cnt_nxt = '0;
          end
        end
      end
      sfm_pkg::KIND_TEXT: begin
        emit        = pat_complete_r;
        cmd.is_text = 1'b1;
        cmd.win     = room;
        cmd.check   = room && (cnt_x >= len_x) && (pat_len_r != '0);
        cmd.offset  = diff_x[sfm_pkg::OFF_W-1:0];
        if (accept && pat_complete_r) begin
          text_cnt_nxt = in_data.last ? '0 : cnt_new;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_complete_r <= 1'b0;
      pat_len_r      <= '0;
      text_cnt_r     <= '0;
    end else begin
      pat_complete_r <= pat_complete_nxt;
      pat_len_r      <= pat_len_nxt;
      text_cnt_r     <= text_cnt_nxt;
    end
  end

  assign f_stat.pat_len  = pat_len_r;
  assign f_stat.text_cnt = text_cnt_r;

endmodule
`default_nettype wire

FILE: rtl/core/sfm_queue.sv
`default_nettype none
module sfm_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sfm_pkg::cmd_t    push_cmd,
  input  wire logic             pop,
  output sfm_pkg::cmd_t         head_cmd,
  output sfm_pkg::q_stat_t      q_stat
);

  sfm_pkg::cmd_t               mem_r [sfm_pkg::QUEUE_DEPTH];
  logic [sfm_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [sfm_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sfm_pkg::QPTR_W'(sfm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   sfm_pkg::QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sfm_pkg::QPTR_W'(sfm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   sfm_pkg::QPTR_W'(rd_ptr_r + 1'b1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = sfm_pkg::QCNT_W'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = sfm_pkg::QCNT_W'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = mem_r[rd_ptr_r];
  assign q_stat.valid = cnt_r != '0;
  assign q_stat.full  = cnt_r == sfm_pkg::QCNT_W'(sfm_pkg::QUEUE_DEPTH);

endmodule
`default_nettype wire

FILE: rtl/core/sfm_back.sv
`default_nettype none
module sfm_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfm_pkg::q_stat_t  q_stat,
  input  wire sfm_pkg::cmd_t     head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sfm_pkg::out_word_t     out_data,
  output sfm_pkg::back_stat_t    b_stat
);

  logic [sfm_pkg::BYTE_W-1:0]      pat_sh_r [sfm_pkg::PATTERN_MAX];
  logic [sfm_pkg::BYTE_W-1:0]      win_r    [sfm_pkg::PATTERN_MAX];
  logic [sfm_pkg::BYTE_W-1:0]      win_nxt  [sfm_pkg::PATTERN_MAX];
  logic [sfm_pkg::PLEN_W-1:0]      pat_len_r, pat_len_nxt;
  logic [sfm_pkg::PATTERN_MAX-1:0] eq_nxt, s1_eq_r;

  logic                            s1_valid_r, s1_is_text_r, s1_restart_r;
  logic                            s1_check_r, s1_last_r;
  logic [sfm_pkg::OFF_W-1:0]       s1_offset_r;

  logic                            seen_r, seen_nxt, seen_now, hit;
  logic [sfm_pkg::OFF_W-1:0]       off_r, off_now;
  logic                            out_valid_r, out_valid_nxt;
  sfm_pkg::out_word_t              out_data_r;
  logic                            stall, advance, emit;

  assign stall   = s1_valid_r && s1_is_text_r && s1_last_r && out_valid_r && !out_ready;
  assign pop     = q_stat.valid && !stall;
  assign advance = s1_valid_r && !stall;
  assign emit    = advance && s1_is_text_r && s1_last_r;

  always_comb begin
    win_nxt[0] = head_cmd.data_byte;
    for (int k = 1; k < sfm_pkg::PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    for (int k = 0; k < sfm_pkg::PATTERN_MAX; k++) begin
      eq_nxt[k] = (win_nxt[k] == pat_sh_r[k]) ||
                  (sfm_pkg::PLEN_W'(k) >= pat_len_r);
    end
  end

  always_comb begin
    pat_len_nxt = pat_len_r;
    if (pop && !head_cmd.is_text) begin
      if (head_cmd.restart) begin
        pat_len_nxt = sfm_pkg::PLEN_W'(1);
      end else if (head_cmd.store) begin
        pat_len_nxt = sfm_pkg::PLEN_W'(pat_len_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head_cmd.is_text && head_cmd.store) begin
      pat_sh_r[0] <= head_cmd.data_byte;
      for (int k = 1; k < sfm_pkg::PATTERN_MAX; k++) begin
        pat_sh_r[k] <= pat_sh_r[k-1];
      end
    end
    if (pop && head_cmd.is_text && head_cmd.win) begin
      for (int k = 0; k < sfm_pkg::PATTERN_MAX; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_is_text_r <= head_cmd.is_text;
      s1_restart_r <= head_cmd.restart;
      s1_check_r   <= head_cmd.check;
      s1_last_r    <= head_cmd.last;
      s1_offset_r  <= head_cmd.offset;
      s1_eq_r      <= eq_nxt;
    end
  end

  always_comb begin
    hit      = s1_check_r && !seen_r && (&s1_eq_r);
    seen_now = seen_r || hit;
    off_now  = hit ? s1_offset_r : off_r;
    seen_nxt = seen_r;
    if (advance) begin
      if (!s1_is_text_r) begin
        seen_nxt = s1_restart_r ? 1'b0 : seen_r;
      end else begin
        seen_nxt = s1_last_r ? 1'b0 : seen_now;
      end
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pat_len_r   <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!stall) begin
        s1_valid_r <= q_stat.valid;
      end
      pat_len_r   <= pat_len_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_is_text_r) begin
      off_r <= off_now;
    end
    if (emit) begin
      out_data_r.found       <= seen_now;
      out_data_r.match_start <= seen_now ? off_now : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign b_stat.busy    = s1_valid_r;
  assign b_stat.pat_len = pat_len_r;

endmodule
`default_nettype wire

FILE: rtl/core/substring_first_match.sv
// Result path: last text byte, command queue, window-compare stage, result register.
// Throughput: one pattern or text byte per cycle; a held result word stalls only
// the window-compare stage, and the four-entry queue absorbs the rest until it fills.
// Reset: synchronous, active low; clears pattern length, text count and match state.
// The pattern store and text window are not cleared and are only read once written.
`default_nettype none
`include "substring_first_match_defines.svh"
module substring_first_match (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sfm_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sfm_pkg::out_word_t       out_data
);

  sfm_pkg::q_stat_t      q_stat;
  sfm_pkg::cmd_t         push_cmd, head_cmd;
  sfm_pkg::front_stat_t  f_stat;
  sfm_pkg::back_stat_t   b_stat;
  logic                  push, pop;

  sfm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd),
    .f_stat   (f_stat)
  );

  sfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  sfm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .b_stat    (b_stat)
  );

  `SFM_ASSERT_IMPLY(a_len_sync, !q_stat.valid && !b_stat.busy, f_stat.pat_len == b_stat.pat_len, "front and back pattern length differ while drained")
  `SFM_ASSERT_IMPLY(a_nf_zero, out_valid && !out_data.found, out_data.match_start == '0, "match_start nonzero on a not-found result")
  `SFM_ASSERT_IMPLY(a_bounds, 1'b1, (f_stat.text_cnt <= sfm_pkg::TCNT_W'(sfm_pkg::TEXT_MAX)) && (f_stat.pat_len <= sfm_pkg::PLEN_W'(sfm_pkg::PATTERN_MAX)), "front counter out of range")
  `SFM_ASSERT_NEXT(a_cnt_clear, in_valid && in_ready && (in_data.kind == sfm_pkg::KIND_TEXT) && in_data.last, f_stat.text_cnt == '0, "text count not cleared after final text byte")

endmodule
`default_nettype wire

FILE: tb/substring_first_match_checker.sv
`default_nettype none
module substring_first_match_checker
  import sfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_word_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_word_t out_data,
  output int             fail_count,
  output int             pending_count,
  output int             result_count,
  output int             match_count
);

  logic [BYTE_W-1:0] pat_mem [PATTERN_MAX];
  logic [BYTE_W-1:0] win_mem [PATTERN_MAX];
  int unsigned       pat_len;
  int unsigned       txt_cnt;
  int unsigned       hit_off;
  bit                pat_done;
  bit                hit;
  out_word_t         due_results [$];
  int                mismatches;
  int                seen_results;
  int                seen_matches;

  function automatic bit window_equals_pattern();
    for (int i = 0; i < pat_len; i++) begin
      if (pat_mem[i] != win_mem[pat_len - 1 - i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_mem[i] = '0;
    end
    txt_cnt = 0;
    hit     = 1'b0;
    hit_off = 0;
  endtask

  task automatic scan_word(input in_word_t w);
    out_word_t r;
    if (w.kind == KIND_PATTERN) begin
      if (pat_done) begin
        pat_done = 1'b0;
        pat_len  = 0;
        clear_scan();
      end
      if (pat_len < PATTERN_MAX) begin
        pat_mem[pat_len] = w.data_byte;
        pat_len++;
      end
      if (w.last) begin
        pat_done = 1'b1;
      end
    end else if (pat_done) begin
      if (txt_cnt < TEXT_MAX) begin
        for (int i = PATTERN_MAX - 1; i > 0; i--) begin
          win_mem[i] = win_mem[i - 1];
        end
        win_mem[0] = w.data_byte;
        txt_cnt++;
        if (!hit && pat_len > 0 && txt_cnt >= pat_len && window_equals_pattern()) begin
          hit     = 1'b1;
          hit_off = txt_cnt - pat_len;
        end
      end
      if (w.last) begin
        r.found       = hit;
        r.match_start = hit ? hit_off[OFF_W-1:0] : '0;
        due_results.push_back(r);
        clear_scan();
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      pat_len  = 0;
      pat_done = 1'b0;
      clear_scan();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_results++;
        if (out_data.found === 1'b1) begin
          seen_matches++;
        end
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word: found=%0d start=%0d",
                     out_data.found, out_data.match_start);
          end
        end else begin
          want = due_results.pop_front();
          if (out_data.found !== want.found || out_data.match_start !== want.match_start) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected found=%0d start=%0d, got found=%0d start=%0d",
                       want.found, want.match_start, out_data.found, out_data.match_start);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_word(in_data);
      end
    end
    fail_count    <= mismatches;
    pending_count <= due_results.size();
    result_count  <= seen_results;
    match_count   <= seen_matches;
  end

endmodule
`default_nettype wire

FILE: tb/tb_substring_first_match.sv
`default_nettype none
module tb_substring_first_match;
  import sfm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int LONG_PAT       = 70;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count;
  int pending_count;
  int result_count;
  int match_count;

  int idle_pct   = 0;
  int stall_pct  = 0;
  bit hold_tog   = 1'b0;
  bit hold_seen  = 1'b0;
  int hold_left  = 0;
  int quiet      = 0;
  int sent_words = 0;
  int sent_texts = 0;
  bit have_pattern = 1'b0;
  logic [BYTE_W-1:0] sym_a;
  logic [BYTE_W-1:0] sym_b;
  logic [BYTE_W-1:0] long_pat [LONG_PAT];

  substring_first_match u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  substring_first_match_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .match_count   (match_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic put_word(input logic kind, input logic [BYTE_W-1:0] ch, input logic fin);
    in_word_t w;
    w.kind      = kind;
    w.data_byte = ch;
    w.last      = fin;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sent_words++;
  endtask

  function automatic logic [BYTE_W-1:0] next_symbol();
    if ($urandom_range(99) < 10) begin
      return BYTE_W'($urandom_range(255));
    end
    return $urandom_range(1) ? sym_a : sym_b;
  endfunction

  task automatic random_round();
    int   plen;
    int   tlen;
    logic fin;
    if (!have_pattern || $urandom_range(99) < 70) begin
      sym_a = BYTE_W'($urandom_range(255));
      sym_b = BYTE_W'($urandom_range(255));
      plen  = ($urandom_range(99) < 6) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      for (int i = 0; i < plen; i++) begin
        if (i > 0 && $urandom_range(99) < 5) begin
          put_word(KIND_TEXT, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        put_word(KIND_PATTERN, next_symbol(), i == plen - 1);
      end
      have_pattern = 1'b1;
    end
    tlen = $urandom_range(1, 24);
    for (int i = 0; i < tlen; i++) begin
      // drop the last mark now and then so a following pattern may cut the text short
      fin = (i == tlen - 1) && ($urandom_range(99) >= 6);
      put_word(KIND_TEXT, next_symbol(), fin);
      if (fin) begin
        sent_texts++;
      end
    end
  endtask

  initial begin
    int start_words;
    int start_texts;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    put_word(KIND_TEXT, 8'hFF, 1'b1);
    put_word(KIND_PATTERN, 8'h00, 1'b0);
    put_word(KIND_TEXT, 8'h00, 1'b1);
    put_word(KIND_PATTERN, 8'hFF, 1'b1);
    put_word(KIND_TEXT, 8'hFF, 1'b0);
    put_word(KIND_TEXT, 8'h00, 1'b0);
    put_word(KIND_TEXT, 8'hFF, 1'b1);
    put_word(KIND_TEXT, 8'h00, 1'b1);
    put_word(KIND_TEXT, 8'h00, 1'b0);
    put_word(KIND_PATTERN, 8'h5A, 1'b1);
    put_word(KIND_TEXT, 8'h5A, 1'b1);
    put_word(KIND_TEXT, 8'hA5, 1'b0);
    put_word(KIND_TEXT, 8'h00, 1'b0);
    put_word(KIND_TEXT, 8'h5A, 1'b1);

    for (int i = 0; i < LONG_PAT; i++) begin
      long_pat[i] = BYTE_W'($urandom_range(255));
      put_word(KIND_PATTERN, long_pat[i], i == LONG_PAT - 1);
    end
    for (int i = 0; i < 3; i++) begin
      put_word(KIND_TEXT, BYTE_W'($urandom_range(255)), 1'b0);
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      put_word(KIND_TEXT, long_pat[i], 1'b0);
    end
    put_word(KIND_TEXT, BYTE_W'($urandom_range(255)), 1'b1);
    have_pattern = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 0;
          stall_pct <= 47;
          hold_tog <= ~hold_tog;
        end
        2: begin
          idle_pct = 47;
          stall_pct <= 0;
        end
        default: begin
          idle_pct = 18;
          stall_pct <= 18;
        end
      endcase
      start_words = sent_words;
      start_texts = sent_texts;
      while (sent_words - start_words < 85 || sent_texts - start_texts < 5) begin
        random_round();
      end
    end

    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_count != 0);
    repeat (10) @(posedge clk);

    $display("Checked %0d result words (%0d with a match) against %0d input words",
             result_count, match_count, sent_words);
    $display("Covered stray text, pattern restart, over-long pattern and a long output hold");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
